// ===== rtl/core/shpd_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// shpd_pkg
// Shared types and constants of the sync-header packet deframer.
// ----------------------------------------------------------------------------
package shpd_pkg;

    // Result kinds
    localparam logic [1:0] KIND_PAYLOAD   = 2'd0;
    localparam logic [1:0] KIND_GOOD      = 2'd1;
    localparam logic [1:0] KIND_BAD_SUM   = 2'd2;
    localparam logic [1:0] KIND_TOO_LONG  = 2'd3;

    // Framing constants
    localparam logic [7:0]  SYNC_FIRST    = 8'hAA;
    localparam logic [7:0]  SYNC_SECOND   = 8'hBB;
    localparam logic [7:0]  PREV_IDLE     = 8'hFF;
    localparam int unsigned HEADER_BYTES  = 6;
    localparam logic [16:0] SUM_MODULUS   = 17'd65535;

    // Configuration register map
    localparam int unsigned APB_ADDR_W    = 3;
    localparam logic        REG_MAX_LEN   = 1'b0;
    localparam logic [15:0] MAX_LEN_RESET = 16'd1024;

    typedef struct packed {
        logic [1:0]  kind;
        logic [7:0]  payload_byte;
        logic [15:0] command;
        logic [15:0] serial_number;
        logic [15:0] payload_length;
        logic [15:0] network_id;
    } result_t;

endpackage
`default_nettype wire

// ===== rtl/core/shpd_cfg_regs.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// shpd_cfg_regs
// APB-style configuration register: maximum accepted payload length.
// ----------------------------------------------------------------------------
module shpd_cfg_regs (
    input  wire logic                            aclk,
    input  wire logic                            aresetn,
    input  wire logic                            psel,
    input  wire logic                            penable,
    input  wire logic                            pwrite,
    input  wire logic [shpd_pkg::APB_ADDR_W-1:0] paddr,
    input  wire logic [31:0]                     pwdata,
    output logic [31:0]                          prdata,
    output logic                                 pready,
    output logic [15:0]                          max_len
);
    import shpd_pkg::*;

    logic [15:0] max_len_reg;
    logic [15:0] max_len_next;
    logic        wr_en;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite && (paddr[2] == REG_MAX_LEN);

    always_comb begin
        max_len_next = max_len_reg;
        if (wr_en) begin
            max_len_next = pwdata[15:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            max_len_reg <= MAX_LEN_RESET;
        end else begin
            max_len_reg <= max_len_next;
        end
    end

    // Register index sits in the upper address bit
    assign prdata  = (paddr[2] == REG_MAX_LEN) ? {16'd0, max_len_reg} : 32'd0;
    assign max_len = max_len_reg;

endmodule
`default_nettype wire

// ===== rtl/core/shpd_frame_engine.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// shpd_frame_engine
// Frame state and per-byte decode: sync hunt, header, payload, checksum.
// ----------------------------------------------------------------------------
module shpd_frame_engine (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        step,
    input  wire logic [7:0]  rx_byte,
    input  wire logic [15:0] max_len,
    output logic             emit,
    output shpd_pkg::result_t result
);
    import shpd_pkg::*;

    logic        in_frame_reg,   in_frame_next;
    logic [7:0]  prev_reg,       prev_next;
    logic [16:0] pos_reg,        pos_next;
    logic [47:0] header_reg,     header_next;
    logic [15:0] sum_reg,        sum_next;
    logic [7:0]  check_high_reg, check_high_next;
    logic [15:0] first_word_reg, first_word_next;

    logic [15:0] len;
    logic [16:0] packlen;
    logic [16:0] pos_inc;
    logic [17:0] sum_t;
    logic [15:0] sum_add;
    logic        restart;

    assign len     = header_reg[15:0];
    assign packlen = 17'(HEADER_BYTES) + {1'b0, len};
    assign pos_inc = pos_reg + 17'd1;

    // Signed byte added to the sum, folded mod 65535 unless the total is negative
    always_comb begin
        sum_t = {2'b00, sum_reg} + {{10{rx_byte[7]}}, rx_byte};
        if (sum_t[17]) begin
            sum_add = sum_t[15:0];
        end else if (sum_t[16:0] >= SUM_MODULUS) begin
            sum_add = 16'(sum_t[16:0] - SUM_MODULUS);
        end else begin
            sum_add = sum_t[15:0];
        end
    end

    always_comb begin
        in_frame_next   = in_frame_reg;
        prev_next       = prev_reg;
        pos_next        = pos_reg;
        header_next     = header_reg;
        sum_next        = sum_reg;
        check_high_next = check_high_reg;
        first_word_next = first_word_reg;
        emit            = 1'b0;
        restart         = 1'b0;
        result          = '0;

        if (step) begin
            if (rx_byte == SYNC_FIRST && !in_frame_reg) begin
                prev_next = SYNC_FIRST;
            end else if (rx_byte == SYNC_SECOND && prev_reg == SYNC_FIRST) begin
                // sync pair; also matched inside a frame, where the frame position is kept
                in_frame_next = 1'b1;
                prev_next     = SYNC_SECOND;
            end else if (in_frame_reg) begin
                prev_next = rx_byte;
                pos_next  = pos_inc;
                if (pos_reg < 17'(HEADER_BYTES)) begin
                    header_next = {header_reg[39:0], rx_byte};
                    sum_next    = sum_add;
                    if (pos_inc == 17'(HEADER_BYTES) && header_next[15:0] > max_len) begin
                        emit                  = 1'b1;
                        restart               = 1'b1;
                        result.kind           = KIND_TOO_LONG;
                        result.command        = header_next[47:32];
                        result.serial_number  = header_next[31:16];
                        result.payload_length = header_next[15:0];
                    end
                end else if (pos_reg < packlen) begin
                    sum_next = sum_add;
                    if (pos_reg == 17'(HEADER_BYTES)) begin
                        first_word_next = {rx_byte, 8'd0};
                    end else if (pos_reg == 17'(HEADER_BYTES + 1)) begin
                        first_word_next = {first_word_reg[15:8], rx_byte};
                    end
                    emit                = 1'b1;
                    result.kind         = KIND_PAYLOAD;
                    result.payload_byte = rx_byte;
                end else begin
                    if (pos_reg == packlen) begin
                        check_high_next = rx_byte;
                    end
                    if (pos_inc == packlen + 17'd2) begin
                        emit                  = 1'b1;
                        restart               = 1'b1;
                        result.kind           = ({check_high_reg, rx_byte} == sum_reg) ?
                                                KIND_GOOD : KIND_BAD_SUM;
                        result.command        = header_reg[47:32];
                        result.serial_number  = header_reg[31:16];
                        result.payload_length = len;
                        result.network_id     = (len >= 16'd2) ? first_word_reg : 16'd0;
                    end
                end
            end

            if (restart) begin
                in_frame_next   = 1'b0;
                prev_next       = PREV_IDLE;
                pos_next        = '0;
                header_next     = '0;
                sum_next        = '0;
                check_high_next = '0;
                first_word_next = '0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_frame_reg   <= 1'b0;
            prev_reg       <= PREV_IDLE;
            pos_reg        <= '0;
            header_reg     <= '0;
            sum_reg        <= '0;
            check_high_reg <= '0;
            first_word_reg <= '0;
        end else begin
            in_frame_reg   <= in_frame_next;
            prev_reg       <= prev_next;
            pos_reg        <= pos_next;
            header_reg     <= header_next;
            sum_reg        <= sum_next;
            check_high_reg <= check_high_next;
            first_word_reg <= first_word_next;
        end
    end

endmodule
`default_nettype wire

// ===== rtl/core/sync_header_packet_deframer.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// sync_header_packet_deframer
// Byte-stream deframer: hunts for the sync pair, takes a six-byte header,
// streams the payload out and checks the trailing 16-bit checksum.
// ----------------------------------------------------------------------------
//  Channel  | Direction | Handshake          | Carries
//  s_*      | in        | s_valid / s_ready  | rx_byte, one received byte
//  m_*      | out       | m_valid / m_ready  | kind, payload byte, header words,
//           |           |                    | network id
//  APB      | in / out  | psel, penable      | max_payload_length at 0x0
//
//  One byte per cycle sustained unless a held result stalls; each byte is held
//  in the input register and its result is loaded into the output register.
//  The frame state update is a compare, a counter and a 16-bit add per byte.
//  Reset (aresetn low, synchronous) clears the valid flags of both registers
//  and the frame state; the length limit returns to 1024.
//  A held result stalls only the input register; the next byte is still taken
//  while the input register is empty.
// ----------------------------------------------------------------------------
module sync_header_packet_deframer (
    input  wire logic                            aclk,
    input  wire logic                            aresetn,
    // input byte channel
    input  wire logic                            s_valid,
    output logic                                 s_ready,
    input  wire logic [7:0]                      s_rx_byte,
    // result channel
    output logic                                 m_valid,
    input  wire logic                            m_ready,
    output logic [1:0]                           m_kind,
    output logic [7:0]                           m_payload_byte,
    output logic [15:0]                          m_command,
    output logic [15:0]                          m_serial_number,
    output logic [15:0]                          m_payload_length,
    output logic [15:0]                          m_network_id,
    // configuration port
    input  wire logic                            psel,
    input  wire logic                            penable,
    input  wire logic                            pwrite,
    input  wire logic [shpd_pkg::APB_ADDR_W-1:0] paddr,
    input  wire logic [31:0]                     pwdata,
    output logic [31:0]                          prdata,
    output logic                                 pready
);
    import shpd_pkg::*;

    logic        in_valid_reg, in_valid_next;
    logic [7:0]  in_byte_reg,  in_byte_next;
    logic        out_valid_reg, out_valid_next;
    result_t     out_reg,      out_next;

    logic        advance;
    logic        emit;
    result_t     result;
    logic [15:0] max_len;

    // Advance the held byte whenever the result register is free or draining
    assign advance = in_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready = !in_valid_reg || advance;

    shpd_cfg_regs u_cfg (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .max_len (max_len)
    );

    shpd_frame_engine u_engine (
        .aclk    (aclk),
        .aresetn (aresetn),
        .step    (advance),
        .rx_byte (in_byte_reg),
        .max_len (max_len),
        .emit    (emit),
        .result  (result)
    );

    always_comb begin
        in_valid_next  = in_valid_reg;
        in_byte_next   = in_byte_reg;
        out_valid_next = out_valid_reg;
        out_next       = out_reg;

        // Drop the input slot once its byte has been processed
        if (advance) begin
            in_valid_next = 1'b0;
        end
        // Capture a new transfer
        if (s_valid && s_ready) begin
            in_valid_next = 1'b1;
            in_byte_next  = s_rx_byte;
        end

        // Load the result register, or clear it once its transfer completes
        if (advance) begin
            out_valid_next = emit;
            out_next       = result;
        end else if (m_ready) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
        in_byte_reg <= in_byte_next;
        out_reg     <= out_next;
    end

    assign m_valid          = out_valid_reg;
    assign m_kind           = out_reg.kind;
    assign m_payload_byte   = out_reg.payload_byte;
    assign m_command        = out_reg.command;
    assign m_serial_number  = out_reg.serial_number;
    assign m_payload_length = out_reg.payload_length;
    assign m_network_id     = out_reg.network_id;

endmodule
`default_nettype wire
